// File: hw/rtl/blhr_pkg.sv
// ----------------------------------------------------------------------------
// blhr_pkg
// Types, constants and helpers shared by the Bayer LCh highlight
// reconstruction block.
// ----------------------------------------------------------------------------
package blhr_pkg;

  localparam int SampleBits = 16;
  localparam int OutBits    = 16;

  // register indexes on the configuration port
  localparam int CfgIndexBits = 1;
  localparam logic [CfgIndexBits-1:0] REG_CLIP_LEVEL     = 1'd0;
  localparam logic [CfgIndexBits-1:0] REG_FILTER_PATTERN = 1'd1;

  localparam logic [15:0] ClipReset   = 16'd4096;
  localparam logic [31:0] FilterReset = 32'd2493825940;

  // colour codes of the filter word
  localparam logic [1:0] COL_RED    = 2'd0;
  localparam logic [1:0] COL_GREEN  = 2'd1;
  localparam logic [1:0] COL_BLUE   = 2'd2;
  localparam logic [1:0] COL_GREEN2 = 2'd3;

  // arithmetic widths
  localparam int RatioShift = 28;
  localparam int FracK      = 14;
  localparam int SqBits     = 35;                     // 3*a^2 + b^2
  localparam int DivBits    = SqBits + RatioShift;    // dividend and quotient
  localparam int RootBits   = 32;
  localparam int RadBits    = 2 * RootBits;
  localparam int MagBits    = 18;                     // |3X - S| and S
  localparam int ProdBits   = MagBits + RootBits;
  localparam int NumBits    = ProdBits + 1;
  localparam int QBits      = NumBits - FracK;

  localparam logic [RootBits-1:0] KOne      = RootBits'(1) << FracK;
  localparam logic [NumBits-1:0]  RoundBias = NumBits'(3) << (FracK - 1);
  localparam logic [QBits-1:0]    SatQ      = QBits'(3) << OutBits;
  localparam logic [17:0]         Recip3    = 18'd174763;   // ceil(2^19 / 3)
  localparam int                  Recip3Shift = 19;

  typedef struct packed {
    logic [SampleBits-1:0] top_left;
    logic [SampleBits-1:0] top_right;
    logic [SampleBits-1:0] bottom_left;
    logic [SampleBits-1:0] bottom_right;
    logic [2:0]            row_phase;
    logic                  col_phase;
    logic                  at_border;
  } in_t;

  typedef struct packed {
    logic [OutBits-1:0] pixel_out;
    logic               was_rebuilt;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                  scale;
    logic                  rebuilt;
    logic [OutBits-1:0]    value;
    logic [SampleBits-1:0] r;
    logic [SampleBits-1:0] gmax;
    logic [SampleBits-1:0] b;
    logic [SampleBits-1:0] ro;
    logic [SampleBits-1:0] go;
    logic [SampleBits-1:0] bo;
    logic [SampleBits-1:0] x;
  } job_t;

  // data that rides along the divider and root pipelines
  typedef struct packed {
    logic               scale;
    logic               dzero;
    logic               rebuilt;
    logic [OutBits-1:0] value;
    logic               neg;
    logic [MagBits-1:0] m;
    logic [MagBits-1:0] s;
  } side_t;

  function automatic logic [1:0] colour_at(input logic [31:0] filter,
                                           input logic [2:0] row,
                                           input logic col);
    logic [4:0] pos;
    pos = {row, col, 1'b0};
    return filter[pos +: 2];
  endfunction

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// File: hw/rtl/blhr_fifo.sv
// ----------------------------------------------------------------------------
// blhr_fifo
// Small register queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module blhr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: hw/rtl/blhr_front.sv
// ----------------------------------------------------------------------------
// blhr_front
// Sorts the 2x2 block into R, G and B, checks for clipping and decides
// between border clamp, pass-through, flat hue and full rescaling.
// ----------------------------------------------------------------------------
module blhr_front import blhr_pkg::*; (
  input  in_t         sample,
  input  logic [15:0] clip_level,
  input  logic [31:0] filter_pattern,
  output job_t        job
);

  logic [SampleBits-1:0] v [4];
  logic [SampleBits-1:0] r, b, gmin, gmax, x;
  logic                  have_g, clipped, flat;
  logic [1:0]            code, code0;
  logic [2:0]            row_i;
  logic                  col_i;

  always_comb begin
    v[0] = sample.top_left;
    v[1] = sample.top_right;
    v[2] = sample.bottom_left;
    v[3] = sample.bottom_right;
    r = '0;
    b = '0;
    gmin = '0;
    gmax = '0;
    have_g = 1'b0;
    clipped = 1'b0;
    row_i = '0;
    col_i = 1'b0;
    code = COL_RED;
    for (int i = 0; i < 4; i++) begin
      row_i = sample.row_phase + 3'(i >> 1);
      col_i = sample.col_phase ^ 1'(i & 1);
      code = colour_at(filter_pattern, row_i, col_i);
      if (v[i] > clip_level) begin
        clipped = 1'b1;
      end
      // later samples win for R and B; greens keep min and max
      case (code)
        COL_RED:  r = v[i];
        COL_BLUE: b = v[i];
        default: begin
          if (!have_g) begin
            gmin = v[i];
            gmax = v[i];
            have_g = 1'b1;
          end else begin
            if (v[i] < gmin) gmin = v[i];
            if (v[i] > gmax) gmax = v[i];
          end
        end
      endcase
    end
  end

  assign code0 = colour_at(filter_pattern, sample.row_phase, sample.col_phase);

  always_comb begin
    case (code0)
      COL_RED:  x = r;
      COL_BLUE: x = b;
      default:  x = gmax;
    endcase
  end

  assign flat = (r == gmax) || (gmax == b);

  always_comb begin
    job.r    = r;
    job.gmax = gmax;
    job.b    = b;
    job.ro   = min16(r, clip_level);
    job.go   = min16(gmin, clip_level);
    job.bo   = min16(b, clip_level);
    job.x    = x;
    if (sample.at_border) begin
      job.scale   = 1'b0;
      job.rebuilt = 1'b0;
      job.value   = min16(clip_level, sample.top_left);
    end else if (!clipped) begin
      job.scale   = 1'b0;
      job.rebuilt = 1'b0;
      job.value   = sample.top_left;
    end else begin
      job.scale   = !flat;
      job.rebuilt = 1'b1;
      job.value   = x;
    end
  end

endmodule

// File: hw/rtl/blhr_div.sv
// ----------------------------------------------------------------------------
// blhr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module blhr_div import blhr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [DivBits-1:0] num,
  input  logic [SqBits-1:0]  den,
  input  side_t              in_side,
  output logic               out_valid,
  output logic [DivBits-1:0] quo,
  output side_t              out_side
);

  logic               vld  [DivBits];
  logic [SqBits-1:0]  rem  [DivBits];
  logic [SqBits-1:0]  dvs  [DivBits];
  logic [DivBits-1:0] nrm  [DivBits];
  logic [DivBits-1:0] qacc [DivBits];
  side_t              sd   [DivBits];

  for (genvar j = 0; j < DivBits; j++) begin : g_stage
    logic               p_vld;
    logic [SqBits-1:0]  p_rem;
    logic [SqBits-1:0]  p_den;
    logic [DivBits-1:0] p_num;
    logic [DivBits-1:0] p_quo;
    side_t              p_side;
    logic [SqBits:0]    trial;
    logic               fit;

    if (j == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_den  = den;
      assign p_num  = num;
      assign p_quo  = '0;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[j-1];
      assign p_rem  = rem[j-1];
      assign p_den  = dvs[j-1];
      assign p_num  = nrm[j-1];
      assign p_quo  = qacc[j-1];
      assign p_side = sd[j-1];
    end

    assign trial = {p_rem, p_num[DivBits-1]};
    assign fit   = (trial >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j]  <= fit ? SqBits'(trial - {1'b0, p_den}) : SqBits'(trial);
        dvs[j]  <= p_den;
        nrm[j]  <= {p_num[DivBits-2:0], 1'b0};
        qacc[j] <= {p_quo[DivBits-2:0], fit};
        sd[j]   <= p_side;
      end
    end
  end

  assign out_valid = vld[DivBits-1];
  assign quo       = qacc[DivBits-1];
  assign out_side  = sd[DivBits-1];

endmodule

// File: hw/rtl/blhr_sqrt.sv
// ----------------------------------------------------------------------------
// blhr_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module blhr_sqrt import blhr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [RadBits-1:0]  rad,
  input  side_t               in_side,
  output logic                out_valid,
  output logic [RootBits-1:0] root,
  output side_t               out_side
);

  localparam int RemW = RootBits + 2;

  logic                vld  [RootBits];
  logic [RemW-1:0]     rem  [RootBits];
  logic [RadBits-1:0]  rsh  [RootBits];
  logic [RootBits-1:0] racc [RootBits];
  side_t               sd   [RootBits];

  for (genvar j = 0; j < RootBits; j++) begin : g_stage
    logic                p_vld;
    logic [RemW-1:0]     p_rem;
    logic [RadBits-1:0]  p_rad;
    logic [RootBits-1:0] p_root;
    side_t               p_side;
    logic [RemW+1:0]     trial;
    logic [RemW+1:0]     cand;
    logic                fit;

    if (j == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_rad  = rad;
      assign p_root = '0;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[j-1];
      assign p_rem  = rem[j-1];
      assign p_rad  = rsh[j-1];
      assign p_root = racc[j-1];
      assign p_side = sd[j-1];
    end

    assign trial = {p_rem, p_rad[RadBits-1 -: 2]};
    assign cand  = {2'b00, p_root, 2'b01};
    assign fit   = (trial >= cand);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j]  <= fit ? RemW'(trial - cand) : RemW'(trial);
        rsh[j]  <= {p_rad[RadBits-3:0], 2'b00};
        racc[j] <= {p_root[RootBits-2:0], fit};
        sd[j]   <= p_side;
      end
    end
  end

  assign out_valid = vld[RootBits-1];
  assign root      = racc[RootBits-1];
  assign out_side  = sd[RootBits-1];

endmodule

// File: hw/rtl/blhr_back.sv
// ----------------------------------------------------------------------------
// blhr_back
// Chroma distances, ratio, gain and rescaling of the selected channel.
// The whole pipeline holds while its last stage waits on a full output.
// ----------------------------------------------------------------------------
module blhr_back import blhr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_empty,
  input  job_t job,
  output logic job_pop,
  input  logic out_full,
  output logic out_push,
  output out_t out_item
);

  logic adv;

  // stage 1: sums and squares
  logic                  v1;
  logic [31:0]           sq_a, sq_ao;
  logic [33:0]           sq_b, sq_bo;
  side_t                 sd1;
  logic [MagBits-1:0]    s_sum, x3;
  logic signed [MagBits:0] t_val;
  logic [15:0]           da, dao;
  logic signed [18:0]    eb, ebo;
  logic [16:0]           mb, mbo;
  side_t                 sd1_next;

  // stage 2: distances
  logic               v2;
  logic [SqBits-1:0]  dsq, dsq_o;
  side_t              sd2;

  logic               vq;
  logic [DivBits-1:0] quo;
  side_t              sdq;

  logic                vr;
  logic [RootBits-1:0] root;
  side_t               sdr;

  // stage M: gain product
  logic                vm;
  logic [ProdBits-1:0] prod;
  side_t               sdm;
  logic [RootBits-1:0] gain;

  // stage A: numerator, rounding, saturation test
  logic               va;
  logic [17:0]        qa;
  logic               negz, sat;
  side_t              sda;
  logic [NumBits-1:0] sp, num;
  logic [QBits-1:0]   qfull;
  logic [35:0]        third;

  assign adv      = !(va && out_full);
  assign job_pop  = adv && !job_empty;
  assign out_push = va && !out_full;

  always_comb begin
    s_sum = MagBits'(job.r) + MagBits'(job.gmax) + MagBits'(job.b);
    x3    = MagBits'({job.x, 1'b0}) + MagBits'(job.x);
    t_val = $signed({1'b0, x3}) - $signed({1'b0, s_sum});
    da    = (job.r >= job.gmax) ? job.r - job.gmax : job.gmax - job.r;
    dao   = (job.ro >= job.go) ? job.ro - job.go : job.go - job.ro;
    eb    = $signed({2'b00, job.b, 1'b0}) - $signed({3'b000, job.gmax})
          - $signed({3'b000, job.r});
    ebo   = $signed({2'b00, job.bo, 1'b0}) - $signed({3'b000, job.go})
          - $signed({3'b000, job.ro});
    mb    = eb[18] ? 17'(-eb) : 17'(eb);
    mbo   = ebo[18] ? 17'(-ebo) : 17'(ebo);
    sd1_next.scale   = job.scale;
    sd1_next.dzero   = 1'b0;
    sd1_next.rebuilt = job.rebuilt;
    sd1_next.value   = job.value;
    sd1_next.neg     = t_val[MagBits];
    sd1_next.m       = t_val[MagBits] ? MagBits'(-t_val) : MagBits'(t_val);
    sd1_next.s       = s_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vm <= 1'b0;
      va <= 1'b0;
    end else if (adv) begin
      v1 <= job_pop;
      v2 <= v1;
      vm <= vr;
      va <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_a   <= da * da;
      sq_ao  <= dao * dao;
      sq_b   <= 34'(mb) * 34'(mb);
      sq_bo  <= 34'(mbo) * 34'(mbo);
      sd1    <= sd1_next;
      dsq    <= SqBits'({sq_a, 1'b0}) + SqBits'(sq_a) + SqBits'(sq_b);
      dsq_o  <= SqBits'({sq_ao, 1'b0}) + SqBits'(sq_ao) + SqBits'(sq_bo);
      sd2    <= sd1;
    end
  end

  side_t sd2_div;
  always_comb begin
    sd2_div       = sd2;
    sd2_div.dzero = (dsq == '0);
  end

  blhr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v2),
    .num       ({dsq_o, RatioShift'(0)}),
    .den       (dsq),
    .in_side   (sd2_div),
    .out_valid (vq),
    .quo       (quo),
    .out_side  (sdq)
  );

  blhr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vq),
    .rad       ({1'b0, quo}),
    .in_side   (sdq),
    .out_valid (vr),
    .root      (root),
    .out_side  (sdr)
  );

  assign gain = sdr.dzero ? KOne : root;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= ProdBits'(sdr.m) * ProdBits'(gain);
      sdm  <= sdr;
    end
  end

  always_comb begin
    sp    = NumBits'({sdm.s, FracK'(0)});
    num   = sdm.neg ? sp - NumBits'(prod) : sp + NumBits'(prod);
    qfull = QBits'((num + RoundBias) >> FracK);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      negz <= sdm.neg && (NumBits'(prod) > sp);
      sat  <= (qfull >= SatQ);
      qa   <= qfull[17:0];
      sda  <= sdm;
    end
  end

  // divide by 3 through the reciprocal, exact below 3*2^16
  assign third = qa * Recip3;

  always_comb begin
    out_item.was_rebuilt = sda.rebuilt;
    if (!sda.scale) begin
      out_item.pixel_out = sda.value;
    end else if (negz) begin
      out_item.pixel_out = '0;
    end else if (sat) begin
      out_item.pixel_out = '1;
    end else begin
      out_item.pixel_out = third[Recip3Shift +: OutBits];
    end
  end

endmodule

// File: hw/rtl/bayer_lch_highlight_reconstruct.sv
// ----------------------------------------------------------------------------
// bayer_lch_highlight_reconstruct
// LCh highlight reconstruction for one Bayer pixel per request.
// ----------------------------------------------------------------------------
// Takes one pixel with its 2x2 neighborhood per clock while full is low and
// returns one result per request in order. Throughput is one pixel per cycle
// until the output queue fills; the back pipeline contains the 63-stage ratio
// divider and the 32-stage square root.
// Results wait in a 4-entry output queue; when it fills the back pipeline
// holds and the 4-entry input queue then raises full.
module bayer_lch_highlight_reconstruct import blhr_pkg::*; #(
  parameter int JOB_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  in_t                     sample,
  output logic                    full,
  input  logic                    pop,
  output out_t                    result,
  output logic                    empty,
  input  logic                    cfg_write,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [31:0]             cfg_data
);

  logic [15:0] clip_level;
  logic [31:0] filter_pattern;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_level     <= ClipReset;
      filter_pattern <= FilterReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CLIP_LEVEL:     clip_level     <= cfg_data[15:0];
        REG_FILTER_PATTERN: filter_pattern <= cfg_data;
        default: ;
      endcase
    end
  end

  job_t job_in, job_out;
  logic job_empty, job_pop;
  logic out_full, out_push;
  out_t out_item;

  blhr_front u_front (
    .sample         (sample),
    .clip_level     (clip_level),
    .filter_pattern (filter_pattern),
    .job            (job_in)
  );

  blhr_fifo #(.WIDTH($bits(job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .full  (full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  blhr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  blhr_fifo #(.WIDTH($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_item),
    .full  (out_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

// File: hw/rtl/blhr_checker.sv
// ----------------------------------------------------------------------------
// blhr_checker
// Port-level checks on the highlight reconstruction block.
// ----------------------------------------------------------------------------
module blhr_port_checks import blhr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic full,
  input logic pop,
  input out_t result,
  input logic empty
);

  // no result can come out right after reset: the result queue resets to empty
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind bayer_lch_highlight_reconstruct blhr_port_checks u_blhr_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .result (result),
  .empty  (empty)
);
